[src/lags_pkg.sv]
package lags_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // control from the sequencer to the row window
  typedef struct packed {
    logic push;    // shift rows up, load the fetched row as the lower row
    logic rotate;  // advance the window one column
    logic col_ok;  // window center is an interior column
  } win_ctrl_t;

endpackage

[src/lags_ram.sv]
module lags_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/lags_rule.sv]
module lags_rule (
  input  logic [2:0] above_i,
  input  logic [2:0] mid_i,
  input  logic [2:0] below_i,
  output logic       alive_o
);

  logic [3:0] count;

  always_comb begin
    count = {3'b0, above_i[0]} + {3'b0, above_i[1]} + {3'b0, above_i[2]}
          + {3'b0, mid_i[0]} + {3'b0, mid_i[2]}
          + {3'b0, below_i[0]} + {3'b0, below_i[1]} + {3'b0, below_i[2]};
    alive_o = (count == lags_pkg::BIRTH_COUNT) ||
              ((count == lags_pkg::SURVIVE_COUNT) && mid_i[1]);
  end

endmodule

[src/lags_window.sv]
module lags_window #(
  parameter int GRID_WIDTH = 64
) (
  input  logic                    clk_i,
  input  lags_pkg::win_ctrl_t     ctrl_i,
  input  logic [GRID_WIDTH-1:0]   row_i,
  output logic [GRID_WIDTH-1:0]   row_o
);

  // three previous-generation rows, rotated one column per cycle while rotate is set
  logic [GRID_WIDTH-1:0] above_q, mid_q, below_q;
  logic [GRID_WIDTH-1:0] new_q;
  logic                  cell_next;

  lags_rule u_rule (
    .above_i (above_q[2:0]),
    .mid_i   (mid_q[2:0]),
    .below_i (below_q[2:0]),
    .alive_o (cell_next)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      above_q <= mid_q;
      mid_q   <= below_q;
      below_q <= row_i;
    end else if (ctrl_i.rotate) begin
      above_q <= {above_q[0], above_q[GRID_WIDTH-1:1]};
      mid_q   <= {mid_q[0], mid_q[GRID_WIDTH-1:1]};
      below_q <= {below_q[0], below_q[GRID_WIDTH-1:1]};
      new_q   <= {cell_next & ctrl_i.col_ok, new_q[GRID_WIDTH-1:1]};
    end
  end

  // bit j of new_q holds column j+1; border columns come out dead
  assign row_o = {new_q[GRID_WIDTH-2:0], 1'b0};

endmodule

[src/life_automaton_generation_step_top.sv]
// Game of Life (B3/S23) grid with a fixed dead border.
// Command channel: an item (opcode_i, col_i, row_i, value_i) is taken at a
// rising edge with start_i high and busy_o low. Opcodes: write cell,
// advance one generation, read cell; opcode 3 is ignored.
// Result channel: a read returns alive_o / on_border_o with valid_o high
// for exactly one cycle; there is no back-pressure.
// Sequencing: an interior read waits in S_RD_WAIT before its result is
// registered; a border or off-grid read answers in the next cycle. An
// interior write reads the row when taken and writes it in S_WR_RMW.
// A generation step runs S_FETCH, S_CALC and S_WRBACK per row: the
// single rule unit visits one cell per cycle while a row window rotates,
// and the row store is read and written one row at a time.
// Writes and reads to border or off-grid cells are ignored / reported
// as border; busy_o stays high for the whole step.
// Reset: every row is marked unwritten and reads as dead, so the grid
// is all dead at once with no clearing pass.
module life_automaton_generation_step_top #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] opcode_i,
  input  logic [5:0] col_i,
  input  logic [5:0] row_i,
  input  logic       value_i,
  output logic       valid_o,
  output logic       alive_o,
  output logic       on_border_o
);

  localparam int CW = $clog2(GRID_WIDTH);
  localparam int RW = $clog2(GRID_HEIGHT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_RMW,
    S_RD_WAIT,
    S_FETCH,
    S_CALC,
    S_WRBACK
  } state_e;

  state_e                  state_q, state_d;
  logic [RW-1:0]           rd_q;
  logic [CW-1:0]           col_q;
  logic                    val_q;
  logic [CW-1:0]           k_q;
  logic [GRID_HEIGHT-1:0]  row_vld_q;
  logic                    rvld_q;
  logic                    valid_q, alive_q, bord_q;

  logic                    accept, in_grid, edge_cell, interior;
  logic [RW-1:0]           row_in;
  logic [CW-1:0]           col_in;

  logic                    ram_re, ram_we;
  logic [RW-1:0]           ram_raddr, ram_waddr;
  logic [GRID_WIDTH-1:0]   ram_wdata, ram_rdata, rdata_m, win_row, bit_sel;
  lags_pkg::win_ctrl_t     win_ctrl;

  assign accept    = start_i && (state_q == S_IDLE);
  assign in_grid   = (32'(col_i) < 32'(GRID_WIDTH)) && (32'(row_i) < 32'(GRID_HEIGHT));
  assign edge_cell = (col_i == 6'd0) || (row_i == 6'd0) ||
                     (32'(col_i) == 32'(GRID_WIDTH - 1)) ||
                     (32'(row_i) == 32'(GRID_HEIGHT - 1));
  assign interior  = in_grid && !edge_cell;
  assign row_in    = RW'(row_i);
  assign col_in    = CW'(col_i);

  // rows never written read as dead
  assign rdata_m = rvld_q ? ram_rdata : '0;
  assign bit_sel = {{(GRID_WIDTH-1){1'b0}}, 1'b1} << col_q;

  lags_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lags_window #(
    .GRID_WIDTH (GRID_WIDTH)
  ) u_window (
    .clk_i  (clk_i),
    .ctrl_i (win_ctrl),
    .row_i  (rdata_m),
    .row_o  (win_row)
  );

  always_comb begin
    state_d   = state_q;
    ram_re    = 1'b0;
    ram_raddr = rd_q;
    ram_we    = 1'b0;
    ram_waddr = rd_q;
    ram_wdata = win_row;
    win_ctrl  = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            lags_pkg::OP_WRITE: begin
              if (interior) begin
                ram_re    = 1'b1;
                ram_raddr = row_in;
                state_d   = S_WR_RMW;
              end
            end
            lags_pkg::OP_STEP: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = S_FETCH;
            end
            lags_pkg::OP_READ: begin
              if (interior) begin
                ram_re    = 1'b1;
                ram_raddr = row_in;
                state_d   = S_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_WR_RMW: begin
        ram_we    = 1'b1;
        ram_wdata = (rdata_m & ~bit_sel) | (val_q ? bit_sel : '0);
        state_d   = S_IDLE;
      end
      S_RD_WAIT: begin
        state_d = S_IDLE;
      end
      S_FETCH: begin
        win_ctrl.push = 1'b1;
        // prime the window with rows 0 and 1 before the first row pass
        if (rd_q < RW'(2)) begin
          ram_re    = 1'b1;
          ram_raddr = rd_q + RW'(1);
        end else begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        win_ctrl.rotate = 1'b1;
        win_ctrl.col_ok = k_q < CW'(GRID_WIDTH - 2);
        if (k_q == CW'(GRID_WIDTH - 1)) begin
          state_d = S_WRBACK;
        end
      end
      S_WRBACK: begin
        ram_we    = 1'b1;
        ram_waddr = rd_q - RW'(1);
        if (rd_q == RW'(GRID_HEIGHT - 1)) begin
          state_d = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = rd_q + RW'(1);
          state_d   = S_FETCH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_q      <= '0;
      col_q     <= '0;
      val_q     <= 1'b0;
      k_q       <= '0;
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
      valid_q   <= 1'b0;
      alive_q   <= 1'b0;
      bord_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == S_RD_WAIT) ||
                 (accept && (opcode_i == lags_pkg::OP_READ) && !interior);
      if (ram_re) begin
        rvld_q <= row_vld_q[ram_raddr];
      end
      if (ram_we) begin
        row_vld_q[ram_waddr] <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            rd_q  <= (opcode_i == lags_pkg::OP_STEP) ? '0 : row_in;
            col_q <= col_in;
            val_q <= value_i;
            if ((opcode_i == lags_pkg::OP_READ) && !interior) begin
              alive_q <= 1'b0;
              bord_q  <= 1'b1;
            end
          end
        end
        S_RD_WAIT: begin
          alive_q <= rdata_m[col_q];
          bord_q  <= 1'b0;
        end
        S_FETCH: begin
          k_q <= '0;
          if (rd_q < RW'(2)) begin
            rd_q <= rd_q + RW'(1);
          end
        end
        S_CALC: begin
          k_q <= k_q + CW'(1);
        end
        S_WRBACK: begin
          if (rd_q != RW'(GRID_HEIGHT - 1)) begin
            rd_q <= rd_q + RW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign alive_o     = alive_q;
  assign on_border_o = bord_q;

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q == S_RD_WAIT) ||
                 $past(accept && (opcode_i == lags_pkg::OP_READ))))
    else $error("result strobe without a read item");

  a_border_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && on_border_o) |-> !alive_o)
    else $error("border cell reported alive");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == S_WR_RMW) || (state_q == S_WRBACK)))
    else $error("row store written outside a write or writeback");

  a_wb_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q == S_WRBACK)) |->
      (!ram_wdata[0] && !ram_wdata[GRID_WIDTH-1]))
    else $error("generation row has a live border column");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("row read and written in the same cycle");

endmodule

[bench/tb_life_automaton_generation_step_top.sv]
module tb_life_automaton_generation_step_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_W = 64;
  localparam int GRID_H = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 115;

  typedef struct {
    logic [5:0] col;
    logic [5:0] row;
    logic       alive;
    logic       on_border;
  } cell_read_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic [1:0] opcode_i;
  logic [5:0] col_i;
  logic [5:0] row_i;
  logic       value_i;
  logic       valid_o;
  logic       alive_o;
  logic       on_border_o;

  // model of the cell store, indexed [row][col]
  bit [GRID_W-1:0] life_grid [GRID_H];
  cell_read_t      pending_reads[$];
  int              mismatch_count = 0;
  int              counted_items  = 0;
  int              burst_left     = 0;

  life_automaton_generation_step_top #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .opcode_i   (opcode_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .alive_o    (alive_o),
    .on_border_o(on_border_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit on_edge(logic [5:0] c, logic [5:0] r);
    return (c == 0) || (r == 0) || (c == GRID_W - 1) || (r == GRID_H - 1);
  endfunction

  // B3/S23 over the interior, every count taken from the old generation
  function automatic void advance_generation();
    bit [GRID_W-1:0] prev [GRID_H];
    int n;
    prev = life_grid;
    for (int r = 1; r < GRID_H - 1; r++) begin
      for (int c = 1; c < GRID_W - 1; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) n += prev[r+dr][c+dc];
          end
        end
        life_grid[r][c] = (n == lags_pkg::BIRTH_COUNT) ||
                          ((n == lags_pkg::SURVIVE_COUNT) && prev[r][c]);
      end
    end
  endfunction

  function automatic void predict_item(logic [1:0] op, logic [5:0] c, logic [5:0] r,
                                       logic v);
    cell_read_t exp_read;
    case (op)
      lags_pkg::OP_WRITE: begin
        if (!on_edge(c, r)) life_grid[r][c] = v;
      end
      lags_pkg::OP_STEP: begin
        advance_generation();
      end
      lags_pkg::OP_READ: begin
        exp_read.col       = c;
        exp_read.row       = r;
        exp_read.on_border = on_edge(c, r);
        exp_read.alive     = on_edge(c, r) ? 1'b0 : life_grid[r][c];
        pending_reads.push_back(exp_read);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // sender runs in bursts; start_i drops only at the head of a gap
  task automatic send_item(logic [1:0] op, logic [5:0] c, logic [5:0] r, logic v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk_i);
    start_i  <= 1'b1;
    opcode_i <= op;
    col_i    <= c;
    row_i    <= r;
    value_i  <= v;
    do @(posedge clk_i); while (busy_o);
    predict_item(op, c, r, v);
    if (op != OP_UNUSED && !(op == lags_pkg::OP_WRITE && on_edge(c, r))) counted_items++;
  endtask

  always @(posedge clk_i) begin
    cell_read_t exp_read;
    if (rst_ni && valid_o) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("read result with no read outstanding");
      end else begin
        exp_read = pending_reads.pop_front();
        if (alive_o !== exp_read.alive)
          report_mismatch($sformatf("cell (%0d,%0d) alive %b, expected %b",
                                    exp_read.col, exp_read.row, alive_o, exp_read.alive));
        if (on_border_o !== exp_read.on_border)
          report_mismatch($sformatf("cell (%0d,%0d) on_border %b, expected %b",
                                    exp_read.col, exp_read.row, on_border_o,
                                    exp_read.on_border));
      end
    end
  end

  task automatic test_reset_state();
    send_item(lags_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
    send_item(lags_pkg::OP_READ, 6'd63, 6'd63, 1'b1);
    send_item(lags_pkg::OP_READ, 6'd1, 6'd1, 1'b0);
    send_item(lags_pkg::OP_READ, 6'd62, 6'd62, 1'b1);
    send_item(lags_pkg::OP_READ, 6'd62, 6'd1, 1'b0);
  endtask

  // border writes and the unused opcode must leave the grid alone
  task automatic test_ignored_items();
    send_item(lags_pkg::OP_WRITE, 6'd0, 6'd5, 1'b1);
    send_item(lags_pkg::OP_WRITE, 6'd63, 6'd10, 1'b1);
    send_item(lags_pkg::OP_WRITE, 6'd7, 6'd0, 1'b1);
    send_item(lags_pkg::OP_WRITE, 6'd9, 6'd63, 1'b1);
    send_item(OP_UNUSED, 6'd20, 6'd20, 1'b1);
    send_item(lags_pkg::OP_READ, 6'd0, 6'd5, 1'b1);
    send_item(lags_pkg::OP_READ, 6'd63, 6'd10, 1'b0);
    send_item(lags_pkg::OP_READ, 6'd9, 6'd63, 1'b1);
    send_item(lags_pkg::OP_READ, 6'd20, 6'd20, 1'b0);
  endtask

  // vertical blinker against the right border; after one step cells (61,31), (62,31), (62,30) are read
  task automatic test_blinker_at_border();
    send_item(lags_pkg::OP_WRITE, 6'd62, 6'd30, 1'b1);
    send_item(lags_pkg::OP_WRITE, 6'd62, 6'd31, 1'b1);
    send_item(lags_pkg::OP_WRITE, 6'd62, 6'd32, 1'b1);
    send_item(lags_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);
    send_item(lags_pkg::OP_READ, 6'd61, 6'd31, 1'b0);
    send_item(lags_pkg::OP_READ, 6'd62, 6'd31, 1'b0);
    send_item(lags_pkg::OP_READ, 6'd62, 6'd30, 1'b0);
  endtask

  // mostly pattern-write / step / probe episodes, some raw noise
  task automatic test_random_patterns();
    int base;
    int oc;
    int orow;
    base = counted_items;
    while (counted_items - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        oc   = $urandom_range(0, GRID_W - 6);
        orow = $urandom_range(0, GRID_H - 6);
        repeat ($urandom_range(3, 10))
          send_item(lags_pkg::OP_WRITE, 6'(oc + $urandom_range(0, 5)),
                    6'(orow + $urandom_range(0, 5)), 1'($urandom_range(0, 4) != 0));
        repeat ($urandom_range(0, 2))
          send_item(lags_pkg::OP_STEP, 6'($urandom), 6'($urandom), 1'($urandom));
        repeat ($urandom_range(2, 6))
          send_item(lags_pkg::OP_READ, 6'(oc + $urandom_range(0, 5)),
                    6'(orow + $urandom_range(0, 5)), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 3))
          send_item(2'($urandom_range(0, 3)), 6'($urandom), 6'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    int guard;
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    opcode_i = lags_pkg::OP_WRITE;
    col_i    = '0;
    row_i    = '0;
    value_i  = 1'b0;
    foreach (life_grid[r]) life_grid[r] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_ignored_items();
    test_blinker_at_border();
    test_random_patterns();

    @(negedge clk_i);
    start_i <= 1'b0;
    guard = 0;
    while ((pending_reads.size() != 0 || busy_o) && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_reads.size() != 0)
      report_mismatch($sformatf("%0d reads never answered", pending_reads.size()));

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
